// ----- rtl/smss_pkg.sv -----
// ----------------------------------------------------------------------------
// Soil moisture sample sequencer package
// Shared widths, codes, result layout and divider handshake types.
// ----------------------------------------------------------------------------
`default_nettype none

package smss_pkg;

  // Field widths
  localparam int ADC_W     = 10;
  localparam int MS_W      = 8;
  localparam int IDX_W     = 3;
  localparam int SUM_W     = 13;
  localparam int PCT_W     = 7;
  localparam int PHASE_W   = 2;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 10;

  // Serial divider widths: dividend covers a scaled difference of up to 1023 * 100
  localparam int DVD_W     = 17;
  localparam int DVS_W     = 10;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  // Event kinds
  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_TRIG = 2'd1;
  localparam logic [OP_W-1:0] OP_CONV = 2'd2;

  // Sequencer phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_SETTLE = 2'd1;
  localparam logic [PHASE_W-1:0] PH_SAMPLE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WET      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRY      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd4;

  // Register reset values
  localparam logic [MS_W-1:0] SETTLE_RST   = 8'd5;
  localparam logic [MS_W-1:0] INTERVAL_RST = 8'd3;

  // Full-scale percentage
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // Result item, last field in the lowest bits
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               range_error;
    logic [PCT_W-1:0]   moisture_percent;
    logic [ADC_W-1:0]   raw_average;
    logic               reading_done;
    logic               start_conversion;
    logic               adc_enabled;
    logic               relay_on;
  } out_item_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/soil_moisture_sample_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// Soil moisture sample sequencer core
// Event-driven measurement sequencer with serial averaging and mapping.
// ----------------------------------------------------------------------------
// Timing: an event that ends no measurement has its result registered on
// acceptance. An event that completes a measurement runs the bit-serial
// divider once for the mean and, when mapping applies, once more for the
// percentage before its result is shown.
// Throughput: one event at a time; the next is taken once no division runs and the
// result register is free. Reset clears the sequencer and loads register defaults at once.
`default_nettype none

module soil_moisture_sample_sequencer_core #(
  parameter int SAMPLES  = 5,
  parameter int ADC_BITS = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Event stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [9:0] adc_value, [15:10] zero
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] opcode
  // Result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [0] relay_on, [1] adc_enabled,
                                           // [2] start_conversion, [3] reading_done,
                                           // [13:4] raw_average, [20:14] moisture_percent,
                                           // [21] range_error, [23:22] phase
  // Register writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [9:0]  cfg_data_i
);

  localparam int ADC_W     = smss_pkg::ADC_W;
  localparam int MS_W      = smss_pkg::MS_W;
  localparam int IDX_W     = smss_pkg::IDX_W;
  localparam int SUM_W     = smss_pkg::SUM_W;
  localparam int MaskBits  = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
  localparam logic [ADC_W-1:0] AdcMask   = ADC_W'((1 << MaskBits) - 1);
  localparam logic [IDX_W-1:0] SampCnt   = IDX_W'(SAMPLES);
  localparam logic [smss_pkg::DVS_W-1:0] SampDiv = smss_pkg::DVS_W'(SAMPLES);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_AVG,
    ST_PCT
  } state_e;

  // Registers
  logic [ADC_W-1:0]             wet_q, dry_q;
  logic                         calib_q;
  logic [MS_W-1:0]              settle_q, interval_q;

  logic [smss_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [MS_W-1:0]              elapsed_q, elapsed_d, elapsed_e;
  logic [IDX_W-1:0]             idx_q, idx_d;
  logic [SUM_W-1:0]             sum_q, sum_d;
  logic [ADC_W-1:0]             latest_q, latest_d, latest_e;
  logic                         ready_q, ready_d, ready_e;
  logic                         trig_q, trig_d, trig_e;
  logic                         start_cv, done_step;

  state_e                       state_q;
  smss_pkg::out_item_t          out_q, out_step;
  logic                         out_valid_q;

  smss_pkg::div_req_t           div_req;
  smss_pkg::div_rsp_t           div_rsp;

  logic                         in_fire;
  logic [smss_pkg::OP_W-1:0]    op;
  logic [ADC_W-1:0]             adc;
  logic [ADC_W-1:0]             avg;
  logic                         span_ok;
  logic                         need_map;
  logic [ADC_W-1:0]             avg_off;
  logic [smss_pkg::DVD_W-1:0]   avg_off_w;
  logic [smss_pkg::DVD_W-1:0]   scaled;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_RUN) && (!out_valid_q || m_axis_tready);
  assign cfg_ready_o   = 1'b1;
  assign op            = s_axis_tuser;
  assign adc           = s_axis_tdata[ADC_W-1:0] & AdcMask;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wet_q      <= '0;
      dry_q      <= '0;
      calib_q    <= 1'b0;
      settle_q   <= smss_pkg::SETTLE_RST;
      interval_q <= smss_pkg::INTERVAL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        smss_pkg::REG_WET:      wet_q      <= cfg_data_i[ADC_W-1:0];
        smss_pkg::REG_DRY:      dry_q      <= cfg_data_i[ADC_W-1:0];
        smss_pkg::REG_CALIB:    calib_q    <= cfg_data_i[0];
        smss_pkg::REG_SETTLE:   settle_q   <= cfg_data_i[MS_W-1:0];
        smss_pkg::REG_INTERVAL: interval_q <= cfg_data_i[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Apply the event's own effect, then one sequencer step
  always_comb begin
    elapsed_e = elapsed_q;
    trig_e    = trig_q;
    latest_e  = latest_q;
    ready_e   = ready_q;
    case (op)
      smss_pkg::OP_TICK: begin
        if (phase_q != smss_pkg::PH_IDLE && elapsed_q != '1) begin
          elapsed_e = elapsed_q + 1'b1;
        end
      end
      smss_pkg::OP_TRIG: trig_e = 1'b1;
      smss_pkg::OP_CONV: begin
        latest_e = adc;
        ready_e  = 1'b1;
      end
      default: ;
    endcase

    phase_d   = phase_q;
    elapsed_d = elapsed_e;
    idx_d     = idx_q;
    sum_d     = sum_q;
    latest_d  = latest_e;
    ready_d   = ready_e;
    trig_d    = trig_e;
    start_cv  = 1'b0;
    done_step = 1'b0;
    case (phase_q)
      smss_pkg::PH_IDLE: begin
        if (trig_e) begin
          trig_d    = 1'b0;
          elapsed_d = '0;
          phase_d   = smss_pkg::PH_SETTLE;
        end
      end
      smss_pkg::PH_SETTLE: begin
        if (elapsed_e >= settle_q) begin
          elapsed_d = '0;
          sum_d     = '0;
          start_cv  = 1'b1;
          phase_d   = smss_pkg::PH_SAMPLE;
        end
      end
      smss_pkg::PH_SAMPLE: begin
        if (elapsed_e >= interval_q && ready_e) begin
          elapsed_d = '0;
          if (idx_q != '0) begin
            sum_d = sum_q + SUM_W'(latest_e);
          end
          if (idx_q >= SampCnt) begin
            idx_d     = '0;
            phase_d   = smss_pkg::PH_IDLE;
            done_step = 1'b1;
          end else begin
            idx_d    = idx_q + 1'b1;
            ready_d  = 1'b0;
            start_cv = 1'b1;
          end
        end
      end
      default: phase_d = smss_pkg::PH_IDLE;
    endcase

    out_step                  = '0;
    out_step.relay_on         = (phase_d != smss_pkg::PH_IDLE);
    out_step.adc_enabled      = (phase_d != smss_pkg::PH_IDLE);
    out_step.start_conversion = start_cv;
    out_step.reading_done     = done_step;
    out_step.phase            = phase_d;
  end

  // Sequencer state, advanced on each accepted event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= smss_pkg::PH_IDLE;
      elapsed_q <= '0;
      idx_q     <= '0;
      sum_q     <= '0;
      latest_q  <= '0;
      ready_q   <= 1'b0;
      trig_q    <= 1'b0;
    end else if (in_fire) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      idx_q     <= idx_d;
      sum_q     <= sum_d;
      latest_q  <= latest_d;
      ready_q   <= ready_d;
      trig_q    <= trig_d;
    end
  end

  // Mean and mapping decisions on the divider result
  always_comb begin
    avg       = div_rsp.quotient[ADC_W-1:0];
    span_ok   = (dry_q > wet_q);
    need_map  = !calib_q && span_ok && (avg > wet_q) && (avg < dry_q);
    avg_off   = avg - wet_q;
    avg_off_w = smss_pkg::DVD_W'(avg_off);
    scaled    = (avg_off_w << 6) + (avg_off_w << 5) + (avg_off_w << 2);
  end

  // Divider requests: mean on a completing event, percentage after the mean when mapping applies
  always_comb begin
    div_req = '0;
    if (in_fire && done_step) begin
      div_req.start    = 1'b1;
      div_req.dividend = smss_pkg::DVD_W'(sum_d);
      div_req.divisor  = SampDiv;
    end else if (state_q == ST_AVG && div_rsp.done && need_map) begin
      div_req.start    = 1'b1;
      div_req.dividend = scaled;
      div_req.divisor  = dry_q - wet_q;
    end
  end

  smss_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Result control and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      case (state_q)
        ST_RUN: begin
          if (in_fire) begin
            out_q <= out_step;
            if (done_step) begin
              out_valid_q <= 1'b0;
              state_q     <= ST_AVG;
            end else begin
              out_valid_q <= 1'b1;
            end
          end else if (m_axis_tready) begin
            out_valid_q <= 1'b0;
          end
        end
        ST_AVG: begin
          if (div_rsp.done) begin
            out_q.raw_average <= avg;
            out_q.range_error <= !calib_q && !span_ok;
            out_q.moisture_percent <= (!calib_q && span_ok && avg >= dry_q) ?
                                      smss_pkg::PCT_FULL : '0;
            if (need_map) begin
              state_q <= ST_PCT;
            end else begin
              out_valid_q <= 1'b1;
              state_q     <= ST_RUN;
            end
          end
        end
        ST_PCT: begin
          if (div_rsp.done) begin
            out_q.moisture_percent <= div_rsp.quotient[smss_pkg::PCT_W-1:0];
            out_valid_q            <= 1'b1;
            state_q                <= ST_RUN;
          end
        end
        default: state_q <= ST_RUN;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // Checks
  a_no_result_while_dividing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_AVG || state_q == ST_PCT) |-> !out_valid_q)
    else $error("result shown before the division finished");
  a_idle_clears_elapsed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == smss_pkg::PH_IDLE) |-> (elapsed_q == '0))
    else $error("elapsed count left over in idle");
  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= SampCnt) else $error("sample index beyond sample count");
  a_done_starts_divider: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && done_step) |=> (state_q == ST_AVG))
    else $error("completed measurement did not start averaging");

endmodule

`default_nettype wire

// ----- rtl/smss_div.sv -----
// ----------------------------------------------------------------------------
// Soil moisture sample sequencer bit-serial divider
// Restoring division, one quotient bit per cycle, quotient shifted into the
// dividend register as the dividend bits leave it.
// ----------------------------------------------------------------------------
`default_nettype none

module smss_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire smss_pkg::div_req_t req_i,
  output smss_pkg::div_rsp_t      rsp_o
);

  logic                                  busy_q;
  logic                                  done_q;
  logic [smss_pkg::DIV_CNT_W-1:0]        cnt_q;
  logic [smss_pkg::DVD_W-1:0]            dvd_q;
  logic [smss_pkg::DVS_W-1:0]            rem_q;
  logic [smss_pkg::DVS_W-1:0]            dvs_q;
  logic [smss_pkg::DVS_W:0]              rem_sh;
  logic [smss_pkg::DVS_W:0]              rem_sub;
  logic                                  fits;

  // Shift in the next dividend bit and trial-subtract the divisor
  always_comb begin
    rem_sh  = {rem_q, dvd_q[smss_pkg::DVD_W-1]};
    fits    = (rem_sh >= {1'b0, dvs_q});
    rem_sub = rem_sh - {1'b0, dvs_q};
  end

  // Control: load on start, count down one bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= smss_pkg::DIV_CNT_W'(smss_pkg::DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == smss_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and dividend/quotient shift register
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub[smss_pkg::DVS_W-1:0] : rem_sh[smss_pkg::DVS_W-1:0];
      dvd_q <= {dvd_q[smss_pkg::DVD_W-2:0], fits};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

  // Checks
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without a running division");
  a_cnt_zero_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !req_i.start && cnt_q == smss_pkg::DIV_CNT_W'(1)) |=> (!busy_q && done_q))
    else $error("divider did not finish on the last bit");
  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != '0)) else $error("divider busy with an empty bit count");

endmodule

`default_nettype wire

// ----- verif/soil_moisture_sample_sequencer_core_tb.sv -----
// ----------------------------------------------------------------------------
// Soil moisture sample sequencer core testbench
// Drives millisecond ticks, triggers and conversion completions through the
// event stream, predicts every result transaction with a cycle-free model of
// the sequencer and compares the result stream field by field. The sender
// works in bursts and the receiver stalls on patterns of its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module soil_moisture_sample_sequencer_core_tb;
  import smss_pkg::*;

  localparam int NUM_SAMPLES  = 5;
  localparam int NUM_ADC_BITS = 10;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 60;

  // Opcode with no effect of its own
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_BURSTY} rx_mode_e;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata;   // [9:0] adc_value, [15:10] zero
  logic [1:0]        s_axis_tuser;   // [1:0] opcode
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [23:0]       m_axis_tdata;   // [0] relay_on, [1] adc_enabled,
                                     // [2] start_conversion, [3] reading_done,
                                     // [13:4] raw_average, [20:14] moisture_percent,
                                     // [21] range_error, [23:22] phase
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [2:0]        cfg_index_i;
  logic [9:0]        cfg_data_i;

  // Sequencer state as the predictor sees it
  logic [PHASE_W-1:0] pr_phase;
  logic [MS_W-1:0]    pr_elapsed;
  logic [IDX_W-1:0]   pr_index;
  logic [SUM_W-1:0]   pr_sum;
  logic [ADC_W-1:0]   pr_latest;
  logic               pr_ready;
  logic               pr_pending;

  // Register copies
  logic [ADC_W-1:0]   cfg_wet;
  logic [ADC_W-1:0]   cfg_dry;
  logic               cfg_calib;
  logic [MS_W-1:0]    cfg_settle;
  logic [MS_W-1:0]    cfg_interval;

  out_item_t expected_readings[$];
  int        error_count;
  int        burst_left;
  int        idle_cycles = 0;

  rx_mode_e  rx_mode = RX_OPEN;
  int        rx_left = 0;
  int        rx_stall = 0;
  int        rx_count = 0;

  soil_moisture_sample_sequencer_core #(
    .SAMPLES (NUM_SAMPLES),
    .ADC_BITS(NUM_ADC_BITS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Apply one event to the sequencer copy and return the reading it gives
  function automatic out_item_t predict_reading(input logic [OP_W-1:0] op,
                                                input logic [ADC_W-1:0] adc);
    out_item_t r;
    int        avg;
    r = '0;
    case (op)
      OP_TICK: begin
        if (pr_phase != PH_IDLE && pr_elapsed != '1) pr_elapsed = pr_elapsed + 1'b1;
      end
      OP_TRIG: pr_pending = 1'b1;
      OP_CONV: begin
        pr_latest = adc & ADC_W'((1 << NUM_ADC_BITS) - 1);
        pr_ready  = 1'b1;
      end
      default: ;
    endcase

    case (pr_phase)
      PH_IDLE: begin
        if (pr_pending) begin
          pr_pending = 1'b0;
          pr_elapsed = '0;
          pr_phase   = PH_SETTLE;
        end
      end
      PH_SETTLE: begin
        if (pr_elapsed >= cfg_settle) begin
          pr_elapsed = '0;
          pr_sum     = '0;
          r.start_conversion = 1'b1;
          pr_phase   = PH_SAMPLE;
        end
      end
      PH_SAMPLE: begin
        if (pr_elapsed >= cfg_interval && pr_ready) begin
          pr_elapsed = '0;
          // The first sample after settling is thrown away
          if (pr_index != 0) pr_sum = pr_sum + pr_latest;
          if (pr_index >= NUM_SAMPLES) begin
            pr_index = '0;
            pr_phase = PH_IDLE;
            avg = int'(pr_sum) / NUM_SAMPLES;
            r.reading_done = 1'b1;
            r.raw_average  = ADC_W'(avg);
            if (!cfg_calib) begin
              if (cfg_dry <= cfg_wet) begin
                r.range_error = 1'b1;
              end else if (avg >= int'(cfg_dry)) begin
                r.moisture_percent = PCT_FULL;
              end else if (avg > int'(cfg_wet)) begin
                r.moisture_percent = PCT_W'(((avg - int'(cfg_wet)) * int'(PCT_FULL)) /
                                            (int'(cfg_dry) - int'(cfg_wet)));
              end
            end
          end else begin
            pr_index = pr_index + 1'b1;
            pr_ready = 1'b0;
            r.start_conversion = 1'b1;
          end
        end
      end
      default: pr_phase = PH_IDLE;
    endcase

    r.relay_on    = (pr_phase != PH_IDLE);
    r.adc_enabled = (pr_phase != PH_IDLE);
    r.phase       = pr_phase;
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Conversion value: full range, the configured span, or a rail
  function automatic logic [ADC_W-1:0] pick_sample();
    int lo;
    int hi;
    lo = (cfg_wet < cfg_dry) ? int'(cfg_wet) : int'(cfg_dry);
    hi = (cfg_wet < cfg_dry) ? int'(cfg_dry) : int'(cfg_wet);
    case ($urandom_range(0, 3))
      0, 1:    return ADC_W'($urandom_range(0, (1 << ADC_W) - 1));
      2:       return ADC_W'($urandom_range(hi, lo));
      default: return ($urandom_range(0, 1) != 0) ? '1 : '0;
    endcase
  endfunction

  function automatic logic [ADC_W-1:0] pick_level();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2:       return '1;
      default: return ADC_W'($urandom_range(0, (1 << ADC_W) - 1));
    endcase
  endfunction

  // Send one event transaction; the sender may pause between bursts
  task automatic send_event(input logic [OP_W-1:0] op, input logic [ADC_W-1:0] adc);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, adc};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_readings.push_back(predict_reading(op, adc));
    @(negedge clk_i);
  endtask

  // Stop sending, let every reading arrive and the block settle
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Leaves the write channel valid; the caller lowers it
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_WET:      cfg_wet      = data[ADC_W-1:0];
      REG_DRY:      cfg_dry      = data[ADC_W-1:0];
      REG_CALIB:    cfg_calib    = data[0];
      REG_SETTLE:   cfg_settle   = data[MS_W-1:0];
      REG_INTERVAL: cfg_interval = data[MS_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [ADC_W-1:0] wet, input logic [ADC_W-1:0] dry,
                            input logic calib, input logic [MS_W-1:0] settle,
                            input logic [MS_W-1:0] interval);
    write_register(REG_WET, CFG_DAT_W'(wet));
    write_register(REG_DRY, CFG_DAT_W'(dry));
    write_register(REG_CALIB, CFG_DAT_W'(calib));
    write_register(REG_SETTLE, CFG_DAT_W'(settle));
    write_register(REG_INTERVAL, CFG_DAT_W'(interval));
    cfg_valid_i <= 1'b0;
  endtask

  // Well-formed measurement with random samples and a share of stray events
  task automatic run_measurement(input bit with_trigger, input int noise_pct);
    int guard;
    guard = 0;
    if (with_trigger) send_event(OP_TRIG, pick_sample());
    while (pr_phase != PH_IDLE && guard < 3000) begin
      guard++;
      if ($urandom_range(0, 99) < noise_pct) begin
        send_event(OP_W'($urandom_range(0, (1 << OP_W) - 1)), pick_sample());
      end else if (pr_phase == PH_SAMPLE && pr_elapsed >= cfg_interval && !pr_ready) begin
        send_event(OP_CONV, pick_sample());
      end else begin
        send_event(OP_TICK, pick_sample());
      end
    end
  endtask

  // Register defaults: stray events in idle, a repeated trigger, settling
  task automatic test_reset_defaults();
    send_event(OP_UNUSED, '0);
    send_event(OP_TICK, '0);
    send_event(OP_CONV, 10'h3FF);
    send_event(OP_TRIG, '0);
    send_event(OP_TRIG, '0);
    repeat (5) send_event(OP_TICK, '0);
    send_event(OP_CONV, 10'h155);
  endtask

  // Zero delays, full span, rail samples, pending trigger restarting
  task automatic test_directed_extremes();
    wait_quiet();
    set_config('0, '1, 1'b0, '0, '0);
    send_event(OP_CONV, 10'h000);
    send_event(OP_CONV, 10'h3FF);
    send_event(OP_CONV, 10'h2AA);
    send_event(OP_CONV, 10'h3FF);
    send_event(OP_CONV, 10'h3FF);
    send_event(OP_CONV, 10'h3FF);
    send_event(OP_TICK, '0);
    send_event(OP_UNUSED, 10'h3FF);
    run_measurement(1'b0, 0);
  endtask

  // Writes beyond the last register must leave the settings alone
  task automatic test_ignored_registers();
    wait_quiet();
    set_config(10'd100, 10'd900, 1'b0, 8'd1, 8'd1);
    @(negedge clk_i);
    for (int idx = int'(REG_INTERVAL) + 1; idx < (1 << CFG_IDX_W); idx++) begin
      write_register(CFG_IDX_W'(idx), CFG_DAT_W'($urandom_range(0, (1 << CFG_DAT_W) - 1)));
    end
    cfg_valid_i <= 1'b0;
    run_measurement(1'b1, 0);
    run_measurement(1'b1, 0);
  endtask

  task automatic test_mapping_random();
    logic [ADC_W-1:0] wet;
    logic [ADC_W-1:0] dry;
    for (int p = 0; p < 6; p++) begin
      wait_quiet();
      wet = pick_level();
      dry = pick_level();
      // Hold the range empty or inverted now and then
      if ($urandom_range(0, 5) == 0) dry = ADC_W'($urandom_range(0, int'(wet)));
      set_config(wet, dry, 1'b0, MS_W'($urandom_range(0, 4)), MS_W'($urandom_range(0, 4)));
      repeat (4) run_measurement(1'b1, 15);
    end
  endtask

  task automatic test_calibrate_random();
    for (int p = 0; p < 2; p++) begin
      wait_quiet();
      set_config(pick_level(), pick_level(), 1'b1, MS_W'($urandom_range(0, 2)),
                 MS_W'($urandom_range(0, 2)));
      repeat (3) run_measurement(1'b1, 10);
    end
  endtask

  // Longest delays, with the tick count saturating while no sample waits
  task automatic test_long_delays();
    wait_quiet();
    set_config(10'h155, 10'h2AA, 1'b0, '1, '1);
    send_event(OP_TRIG, '0);
    while (pr_phase != PH_SAMPLE) send_event(OP_TICK, pick_sample());
    send_event(OP_CONV, pick_sample());
    while (pr_index == 0) send_event(OP_TICK, pick_sample());
    repeat (270) send_event(OP_TICK, pick_sample());
    send_event(OP_CONV, pick_sample());
    wait_quiet();
    set_config(10'h155, 10'h2AA, 1'b0, '0, '0);
    run_measurement(1'b0, 10);
  endtask

  // Unordered events of every kind
  task automatic test_random_noise();
    wait_quiet();
    set_config(pick_level(), pick_level(), 1'($urandom_range(0, 1)),
               MS_W'($urandom_range(0, 3)), MS_W'($urandom_range(0, 3)));
    repeat (150) begin
      send_event(OP_W'($urandom_range(0, (1 << OP_W) - 1)), pick_sample());
    end
  endtask

  // Receiver stall patterns
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 300);
    end
    rx_left--;
    rx_count++;
    case (rx_mode)
      RX_OPEN:     m_axis_tready <= 1'b1;
      RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 9) < 7);
      RX_PERIODIC: m_axis_tready <= (rx_count % 4 == 0);
      default: begin
        if (rx_stall > 0) begin
          rx_stall--;
          m_axis_tready <= 1'b0;
        end else begin
          rx_stall = $urandom_range(0, 15);
          m_axis_tready <= 1'b1;
        end
      end
    endcase
  end

  // Compare each result transaction with the oldest expected reading
  always @(posedge clk_i) begin
    out_item_t got;
    out_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = out_item_t'(m_axis_tdata);
      if (expected_readings.size() == 0) begin
        $error("result with no reading expected: %h", m_axis_tdata);
        error_count++;
      end else begin
        want = expected_readings.pop_front();
        check_field("relay_on", want.relay_on, got.relay_on);
        check_field("adc_enabled", want.adc_enabled, got.adc_enabled);
        check_field("start_conversion", want.start_conversion, got.start_conversion);
        check_field("reading_done", want.reading_done, got.reading_done);
        check_field("raw_average", want.raw_average, got.raw_average);
        check_field("moisture_percent", want.moisture_percent, got.moisture_percent);
        check_field("range_error", want.range_error, got.range_error);
        check_field("phase", want.phase, got.phase);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_TICK;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_WET;
    cfg_data_i    = '0;
    error_count   = 0;
    burst_left    = 0;
    pr_phase      = PH_IDLE;
    pr_elapsed    = '0;
    pr_index      = '0;
    pr_sum        = '0;
    pr_latest     = '0;
    pr_ready      = 1'b0;
    pr_pending    = 1'b0;
    cfg_wet       = '0;
    cfg_dry       = '0;
    cfg_calib     = 1'b0;
    cfg_settle    = SETTLE_RST;
    cfg_interval  = INTERVAL_RST;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_directed_extremes();
    test_ignored_registers();
    test_mapping_random();
    test_calibrate_random();
    test_long_delays();
    test_random_noise();
    wait_quiet();

    if (error_count == 0 && expected_readings.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/smss_pkg.sv
rtl/smss_div.sv
rtl/soil_moisture_sample_sequencer_core.sv
verif/soil_moisture_sample_sequencer_core_tb.sv
